// File: hdl/ssbg_pkg.sv
// Shared constants for the spectral subtraction bin gain block.
`default_nettype none

package ssbg_pkg;

  localparam int BINS_DEF   = 4096;
  localparam int BIN_W      = 12;
  localparam int PART_W     = 24;
  localparam int POW_W      = 48;
  localparam int GAIN_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [GAIN_W-1:0] SQUELCH_RST = 16'd2560;
  localparam logic [GAIN_W-1:0] OUTGAIN_RST = 16'd0;

  localparam logic REG_SQUELCH = 1'b0;
  localparam logic REG_OUTGAIN = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PROC = 1'b1;

  localparam logic signed [PART_W-1:0] PART_MAX = 24'sh7FFFFF;
  localparam logic signed [PART_W-1:0] PART_MIN = -24'sh800000;

endpackage

`default_nettype wire

// File: hdl/ssbg_if.sv
// Valid/ready stream interfaces for input and result transfers.
`default_nettype none

interface ssbg_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    func;
  logic        [ssbg_pkg::BIN_W-1:0]       bin_index;
  logic signed [ssbg_pkg::PART_W-1:0]      re_in;
  logic signed [ssbg_pkg::PART_W-1:0]      im_in;
  logic        [ssbg_pkg::POW_W-1:0]       ref_power;

  modport source (output valid, func, bin_index, re_in, im_in, ref_power, input ready);
  modport sink   (input valid, func, bin_index, re_in, im_in, ref_power, output ready);
endinterface

interface ssbg_out_if;
  logic                                    valid;
  logic                                    ready;
  logic        [ssbg_pkg::BIN_W-1:0]       bin_out;
  logic signed [ssbg_pkg::PART_W-1:0]      re_out;
  logic signed [ssbg_pkg::PART_W-1:0]      im_out;
  logic                                    saturated;

  modport source (output valid, bin_out, re_out, im_out, saturated, input ready);
  modport sink   (input valid, bin_out, re_out, im_out, saturated, output ready);
endinterface

`default_nettype wire

// File: hdl/ssbg_ram.sv
// Simple dual-port RAM with registered read.
`default_nettype none

module ssbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/spectral_subtraction_bin_gain.sv
// Top level: pipelined per-bin spectral subtraction gain.
//
//  channel  | dir | handshake           | payload
//  in_i     | in  | valid/ready         | func, bin_index, re_in, im_in, ref_power
//  out_o    | out | valid/ready         | bin_out, re_out, im_out, saturated
//  apb      | in  | psel/penable/pready | paddr, pwdata, prdata
//
// One item per cycle while no result waits untaken and no clearing pass runs.
// The divider and square root pipelines each have 17 stages.
// In-range loads write the table at transfer; loads give no result.
// After reset a clearing pass zeroes every table entry; no input is taken then.
// A result not taken freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none

module spectral_subtraction_bin_gain #(
  parameter int BINS = ssbg_pkg::BINS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  ssbg_in_if.sink                                  in_i,
  ssbg_out_if.source                               out_o,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ssbg_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ssbg_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ssbg_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int AW     = $clog2(BINS);
  localparam int NDIV   = 17;
  localparam int NSQ    = 17;
  localparam int S_DIV  = 4;
  localparam int S_SQ   = S_DIV + NDIV;
  localparam int S_GAIN = S_SQ + NSQ;
  localparam int S_MUL  = S_GAIN + 1;
  localparam int S_OUT  = S_MUL + 1;
  localparam int NST    = S_OUT + 1;

  typedef struct packed {
    logic        [ssbg_pkg::BIN_W-1:0]  bin;
    logic signed [ssbg_pkg::PART_W-1:0] re;
    logic signed [ssbg_pkg::PART_W-1:0] im;
    logic                               zero;
  } pay_t;

  logic [ssbg_pkg::GAIN_W-1:0] sq_q, og_q;
  logic                        apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= ssbg_pkg::SQUELCH_RST;
      og_q <= ssbg_pkg::OUTGAIN_RST;
    end else if (apb_wr) begin
      unique case (paddr[2])
        ssbg_pkg::REG_SQUELCH: sq_q <= pwdata[ssbg_pkg::GAIN_W-1:0];
        ssbg_pkg::REG_OUTGAIN: og_q <= pwdata[ssbg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ssbg_pkg::REG_OUTGAIN: prdata = ssbg_pkg::APB_DATA_W'(og_q);
      default:               prdata = ssbg_pkg::APB_DATA_W'(sq_q);
    endcase
  end

  // Pipeline control
  logic           v_q [NST];
  pay_t           pay_q [NST];
  pay_t           pay_d [NST];
  logic           en, acc, clr_q, in_range;
  logic [AW-1:0]  clr_cnt_q, bin_addr;
  logic [31:0]    bin_w;

  assign en          = !v_q[S_OUT] || out_o.ready;
  assign in_i.ready  = en && !clr_q;
  assign acc         = in_i.valid && in_i.ready;
  assign bin_w       = 32'(in_i.bin_index);
  assign bin_addr    = bin_w[AW-1:0];
  assign in_range    = bin_w < BINS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(BINS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  logic [ssbg_pkg::POW_W-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_we;

  assign ram_we    = clr_q || (acc && in_i.func == ssbg_pkg::FUNC_LOAD && in_range);
  assign ram_waddr = clr_q ? clr_cnt_q : bin_addr;
  assign ram_wdata = clr_q ? '0 : in_i.ref_power;

  ssbg_ram #(
    .WIDTH(ssbg_pkg::POW_W),
    .DEPTH(BINS)
  ) u_ref_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (acc),
    .raddr_i(bin_addr),
    .rdata_o(ram_rdata)
  );

  // Datapath registers
  logic                       ok0_q;
  logic [46:0]                rr1_q, ii1_q;
  logic [63:0]                sub1_q, sub2_q;
  logic [ssbg_pkg::POW_W-1:0] pow2_q, pow3_q, masked3_q;
  logic [ssbg_pkg::POW_W-1:0] drem_q [NDIV];
  logic [ssbg_pkg::POW_W-1:0] drem_d [NDIV];
  logic [ssbg_pkg::POW_W-1:0] dpow_q [NDIV];
  logic [ssbg_pkg::POW_W-1:0] dpow_d [NDIV];
  logic [NDIV-1:0]            dq_q [NDIV];
  logic [NDIV-1:0]            dq_d [NDIV];
  logic [NSQ-1:0]             sy_q [NSQ];
  logic [NSQ-1:0]             sy_d [NSQ];
  logic [32:0]                srem_q [NSQ];
  logic [32:0]                srem_d [NSQ];
  logic [32:0]                gain_q;
  logic signed [57:0]         pre_q, pim_q;

  logic signed [47:0] rr_w, ii_w;
  logic [63:0]        sub_w, scaled_w;
  logic [32:0]        gain_w;
  logic signed [57:0] pre_w, pim_w, sre_w, sim_w;
  logic signed [ssbg_pkg::PART_W-1:0] ore_w, oim_w;
  logic               sat_re_w, sat_im_w;

  assign rr_w     = pay_q[0].re * pay_q[0].re;
  assign ii_w     = pay_q[0].im * pay_q[0].im;
  assign sub_w    = ok0_q ? ram_rdata * sq_q : 64'd0;
  assign scaled_w = {8'd0, pow2_q, 8'd0};

  always_comb begin
    for (int k = 0; k < NST; k++) begin
      pay_d[k] = (k == 0) ? pay_q[0] : pay_q[k-1];
    end
    pay_d[3].zero = (pow2_q == '0);
  end

  always_comb begin
    logic [48:0] t;
    logic        b;
    for (int j = 0; j < NDIV; j++) begin
      if (j == 0) begin
        b         = masked3_q >= pow3_q;
        drem_d[j] = b ? masked3_q - pow3_q : masked3_q;
        dq_d[j]   = NDIV'(b);
        dpow_d[j] = pow3_q;
      end else begin
        t         = {drem_q[j-1], 1'b0};
        b         = t >= {1'b0, dpow_q[j-1]};
        drem_d[j] = b ? ssbg_pkg::POW_W'(t - {1'b0, dpow_q[j-1]}) : t[47:0];
        dq_d[j]   = {dq_q[j-1][NDIV-2:0], b};
        dpow_d[j] = dpow_q[j-1];
      end
    end
  end

  always_comb begin
    logic [NSQ-1:0] y;
    logic [32:0]    r;
    logic [34:0]    trial;
    for (int k = 0; k < NSQ; k++) begin
      if (k == 0) begin
        y = '0;
        r = {dq_q[NDIV-1], 16'd0};
      end else begin
        y = sy_q[k-1];
        r = srem_q[k-1];
      end
      trial = ({18'd0, y} << (NSQ - k)) + (35'd1 << (2 * (NSQ - 1 - k)));
      if ({2'b0, r} >= trial) begin
        srem_d[k] = 33'({2'b0, r} - trial);
        sy_d[k]   = y | (NSQ'(1) << (NSQ - 1 - k));
      end else begin
        srem_d[k] = r;
        sy_d[k]   = y;
      end
    end
  end

  assign gain_w = pay_q[S_GAIN-1].zero ? 33'd0 : sy_q[NSQ-1] * og_q;
  assign pre_w  = pay_q[S_MUL-1].re * $signed({1'b0, gain_q});
  assign pim_w  = pay_q[S_MUL-1].im * $signed({1'b0, gain_q});
  assign sre_w  = pre_q >>> 28;
  assign sim_w  = pim_q >>> 28;

  always_comb begin
    sat_re_w = 1'b1;
    sat_im_w = 1'b1;
    if (sre_w > 58'(ssbg_pkg::PART_MAX)) begin
      ore_w = ssbg_pkg::PART_MAX;
    end else if (sre_w < 58'(ssbg_pkg::PART_MIN)) begin
      ore_w = ssbg_pkg::PART_MIN;
    end else begin
      ore_w    = sre_w[ssbg_pkg::PART_W-1:0];
      sat_re_w = 1'b0;
    end
    if (sim_w > 58'(ssbg_pkg::PART_MAX)) begin
      oim_w = ssbg_pkg::PART_MAX;
    end else if (sim_w < 58'(ssbg_pkg::PART_MIN)) begin
      oim_w = ssbg_pkg::PART_MIN;
    end else begin
      oim_w    = sim_w[ssbg_pkg::PART_W-1:0];
      sat_im_w = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v_q[0] <= acc && in_i.func == ssbg_pkg::FUNC_PROC;
      for (int k = 1; k < NST; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  logic signed [ssbg_pkg::PART_W-1:0] re_out_q, im_out_q;
  logic [ssbg_pkg::BIN_W-1:0]         bin_out_q;
  logic                               sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= '{bin: in_i.bin_index, re: in_i.re_in, im: in_i.im_in, zero: 1'b0};
      ok0_q    <= in_range;
      for (int k = 1; k < NST; k++) begin
        pay_q[k] <= pay_d[k];
      end
      rr1_q     <= rr_w[46:0];
      ii1_q     <= ii_w[46:0];
      sub1_q    <= sub_w;
      pow2_q    <= {1'b0, rr1_q} + {1'b0, ii1_q};
      sub2_q    <= sub1_q;
      pow3_q    <= pow2_q;
      masked3_q <= (scaled_w > sub2_q) ? ssbg_pkg::POW_W'((scaled_w - sub2_q) >> 8) : '0;
      for (int j = 0; j < NDIV; j++) begin
        drem_q[j] <= drem_d[j];
        dq_q[j]   <= dq_d[j];
        dpow_q[j] <= dpow_d[j];
      end
      for (int k = 0; k < NSQ; k++) begin
        sy_q[k]   <= sy_d[k];
        srem_q[k] <= srem_d[k];
      end
      gain_q    <= gain_w;
      pre_q     <= pre_w;
      pim_q     <= pim_w;
      bin_out_q <= pay_q[S_OUT-1].bin;
      re_out_q  <= ore_w;
      im_out_q  <= oim_w;
      sat_q     <= sat_re_w || sat_im_w;
    end
  end

  assign out_o.valid     = v_q[S_OUT];
  assign out_o.bin_out   = bin_out_q;
  assign out_o.re_out    = re_out_q;
  assign out_o.im_out    = im_out_q;
  assign out_o.saturated = sat_q;

endmodule

`default_nettype wire

// File: hdl/ssbg_checker.sv
// Port-level checks for the spectral subtraction bin gain block, with bind.
`default_nettype none

module ssbg_port_props (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [ssbg_pkg::BIN_W-1:0]          out_bin,
  input wire logic signed [ssbg_pkg::PART_W-1:0]  out_re,
  input wire logic signed [ssbg_pkg::PART_W-1:0]  out_im,
  input wire logic                                out_sat,
  input wire logic                                psel,
  input wire logic                                penable,
  input wire logic                                pwrite,
  input wire logic [ssbg_pkg::APB_ADDR_W-1:0]     paddr,
  input wire logic [ssbg_pkg::APB_DATA_W-1:0]     pwdata,
  input wire logic [ssbg_pkg::APB_DATA_W-1:0]     prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_bin) && $stable(out_re) && $stable(out_im)
                                && $stable(out_sat))
    else $error("result changed while stalled");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_sat |->
      out_re == ssbg_pkg::PART_MAX || out_re == ssbg_pkg::PART_MIN ||
      out_im == ssbg_pkg::PART_MAX || out_im == ssbg_pkg::PART_MIN)
    else $error("saturation flag without a clipped part");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite ##1 $stable(paddr) |->
      prdata == ssbg_pkg::APB_DATA_W'($past(pwdata[ssbg_pkg::GAIN_W-1:0])))
    else $error("register readback mismatch");

endmodule

bind spectral_subtraction_bin_gain ssbg_port_props u_ssbg_port_props (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .out_bin  (out_o.bin_out),
  .out_re   (out_o.re_out),
  .out_im   (out_o.im_out),
  .out_sat  (out_o.saturated),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

`default_nettype wire
